/* design/olist_pkg.sv */
// Shared types and codes for the ordered list engine.
// No dependencies; imported by olist_cell and ordered_list_engine.
`default_nettype none

package olist_pkg;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned COUNT_W    = 7;
  // wide enough for any list position or count up to the largest capacity
  localparam int unsigned IDX_W      = 11;

  typedef enum logic [OP_W-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_POS  = 3'd2,
    OP_REM_HEAD = 3'd3,
    OP_REM_TAIL = 3'd4,
    OP_REM_POS  = 3'd5,
    OP_READ     = 3'd6,
    OP_CONTAINS = 3'd7
  } op_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;   // insert succeeds this cycle
    logic             rem;   // remove succeeds this cycle
    logic [IDX_W-1:0] pos;   // target position
    logic [IDX_W-1:0] cnt;   // entries before the operation
  } cell_cmd_t;

endpackage

`default_nettype wire

/* design/ordered_list_engine.sv */
// Ordered list engine top level: request decode, chain of list cells, result register.
// Depends on olist_pkg and olist_cell.
//
// Usage:
//   Requests (op_i, position_i, item_value_i) enter on in_valid_i/in_stall_o;
//   an item is taken at a clock edge with valid high and stall low.
//   Results (status_o, item_out_o, found_o, count_o) leave on
//   out_valid_o/out_stall_i, one result per request, in request order.
//   Results are registered: the result of a request taken at an edge is shown
//   after that edge and stays until the receiver takes it.
//   Throughput is one request per cycle unless a result waits under out_stall_i.
//   Each operation is done at its accepting edge: all cells shift toward or away
//   from the target position at once and compare against the search value in parallel.
//   While a result waits under out_stall_i the block raises in_stall_o, so a
//   new request is taken in the same cycle the pending result leaves.
//   Reset (rst_ni low, asynchronous) empties the list and drops any pending
//   result; cell contents are not cleared, only the entry count.
`default_nettype none

module ordered_list_engine
  import olist_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [OP_W-1:0]    op_i,
  input  wire logic [POS_W-1:0]   position_i,
  input  wire logic [VALUE_W-1:0] item_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    status_o,
  output logic [VALUE_W-1:0]      item_out_o,
  output logic                    found_o,
  output logic [COUNT_W-1:0]      count_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] Cap = IDX_W'(CAPACITY);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q;
  logic            status_q, found_q;
  logic [VALUE_W-1:0] item_q;
  logic [COUNT_W-1:0] count_q;

  logic            in_acc;
  logic [IDX_W-1:0] cnt_x, pos_x, tgt;
  logic            is_ins, is_rem, is_rd, is_has, ok;
  logic [ITEM_WIDTH-1:0] key;
  logic [VALUE_W-1:0]    item_res;
  cell_cmd_t       cmd;

  logic [ITEM_WIDTH-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]   cell_match, cell_sel;
  logic [ITEM_WIDTH-1:0] sel_val;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign cnt_x = IDX_W'(cnt_q);
  assign pos_x = IDX_W'(position_i);

  generate
    if (ITEM_WIDTH <= VALUE_W) begin : g_narrow
      assign key      = item_value_i[ITEM_WIDTH-1:0];
      assign item_res = VALUE_W'(sel_val);
    end else begin : g_wide
      assign key      = ITEM_WIDTH'(item_value_i);
      assign item_res = sel_val[VALUE_W-1:0];
    end
  endgenerate

  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    is_rd  = 1'b0;
    is_has = 1'b0;
    tgt    = pos_x;
    unique case (op_e'(op_i))
      OP_INS_HEAD: begin is_ins = 1'b1; tgt = '0;              end
      OP_INS_TAIL: begin is_ins = 1'b1; tgt = cnt_x;           end
      OP_INS_POS:  begin is_ins = 1'b1; tgt = pos_x;           end
      OP_REM_HEAD: begin is_rem = 1'b1; tgt = '0;              end
      // an empty list wraps this to all ones, which fails the range check
      OP_REM_TAIL: begin is_rem = 1'b1; tgt = cnt_x - 1'b1;    end
      OP_REM_POS:  begin is_rem = 1'b1; tgt = pos_x;           end
      OP_READ:     begin is_rd  = 1'b1; tgt = pos_x;           end
      OP_CONTAINS: begin is_has = 1'b1;                        end
      default:     begin is_has = 1'b1;                        end
    endcase
  end

  always_comb begin
    ok = 1'b1;
    if (is_ins) begin
      ok = (cnt_x < Cap) && (tgt <= cnt_x);
    end else if (is_rem || is_rd) begin
      ok = (tgt < cnt_x);
    end
  end

  always_comb begin
    cmd.ins = in_acc && is_ins && ok;
    cmd.rem = in_acc && is_rem && ok;
    cmd.pos = tgt;
    cmd.cnt = cnt_x;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ITEM_WIDTH-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = key;
    end else begin : g_mid
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_inner
      assign right_v = cell_val[i+1];
    end
    olist_cell #(
      .IDX        (i),
      .ITEM_WIDTH (ITEM_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left_v),
      .right_i (right_v),
      .new_i   (key),
      .value_o (cell_val[i]),
      .match_o (cell_match[i]),
      .sel_o   (cell_sel[i])
    );
  end

  // one-hot AND-OR select of the target cell
  always_comb begin
    sel_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_val = sel_val | (cell_val[i] & {ITEM_WIDTH{cell_sel[i]}});
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd.ins) begin
      cnt_d = cnt_q + 1'b1;
    end else if (cmd.rem) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q <= !ok;
      item_q   <= ((is_rem || is_rd) && ok) ? item_res : '0;
      found_q  <= is_has && (|cell_match);
      count_q  <= COUNT_W'(cnt_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign item_out_o  = item_q;
  assign found_o     = found_q;
  assign count_o     = count_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_x <= Cap)
    else $error("entry count above capacity");

  a_fail_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !ok |=> cnt_q == $past(cnt_q))
    else $error("failed request changed the entry count");

  a_acc_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted request produced no result");

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_o == COUNT_W'(cnt_q))
    else $error("reported count differs from list state");

endmodule

`default_nettype wire

/* design/olist_cell.sv */
// One list cell: holds the entry at a fixed position and shifts with its neighbors.
// Depends on olist_pkg.
`default_nettype none

module olist_cell
  import olist_pkg::*;
#(
  parameter int unsigned IDX        = 0,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire cell_cmd_t             cmd_i,
  input  wire logic [ITEM_WIDTH-1:0] left_i,
  input  wire logic [ITEM_WIDTH-1:0] right_i,
  input  wire logic [ITEM_WIDTH-1:0] new_i,
  output logic      [ITEM_WIDTH-1:0] value_o,
  output logic                       match_o,
  output logic                       sel_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic [ITEM_WIDTH-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    priority if (cmd_i.ins && (MyIdx > cmd_i.pos)) begin
      value_d = left_i;
    end else if (cmd_i.ins && (MyIdx == cmd_i.pos)) begin
      value_d = new_i;
    end else if (cmd_i.rem && (MyIdx >= cmd_i.pos)) begin
      value_d = right_i;
    end else begin
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign match_o = (MyIdx < cmd_i.cnt) && (value_q == new_i);
  assign sel_o   = (MyIdx == cmd_i.pos);

endmodule

`default_nettype wire
